// File: rtl/lps_pkg.sv
// Shared types and constants of the LED pattern sequencer.
package lps_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_LED_MASK      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_STANDBY_DELAY = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ON_DELAY      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CLASH_DELAY   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LOCKUP_DELAY  = 3'd4;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_STATUS = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;

    localparam logic [2:0] ST_STANDBY = 3'd1;
    localparam logic [2:0] ST_LOCKUP  = 3'd4;

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_ON      = 2'd1;
    localparam logic [1:0] MODE_CLASH   = 2'd2;
    localparam logic [1:0] MODE_LOCKUP  = 2'd3;

    localparam logic [7:0]  MASK_RESET   = 8'hFF;
    localparam logic [15:0] DELAY_RESET  = 16'd100;
    localparam logic [15:0] SLEEP_RELOAD = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_STATUS,
        OP_LOAD,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        PS_HOLD,
        PS_ZERO,
        PS_MEM
    } t_pin_src;

    typedef struct packed {
        t_op        op;
        logic [7:0] elapsed_ms;
        logic [2:0] status;
        logic [1:0] mode;
        logic [5:0] step_index;
        logic [7:0] entry_value;
        logic       final_entry;
    } t_cmd;

    typedef struct packed {
        logic                valid;
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg_wr;

endpackage

// File: rtl/lps_if.sv
// Request channels of the LED pattern sequencer: input items and result items.
interface lps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] elapsed_ms;
    logic [2:0] status;
    logic [1:0] mode;
    logic [5:0] step_index;
    logic [7:0] entry_value;
    logic       final_entry;

    modport source (output valid, action, elapsed_ms, status, mode, step_index,
                    entry_value, final_entry, input ready);
    modport sink (input valid, action, elapsed_ms, status, mode, step_index,
                  entry_value, final_entry, output ready);
endinterface

interface lps_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] pin_drive;
    logic       pins_updated;

    modport source (output valid, pin_drive, pins_updated, input ready);
    modport sink (input valid, pin_drive, pins_updated, output ready);
endinterface

// File: rtl/led_pattern_sequencer.sv
// Top level of the LED pattern sequencer: front end, command queue and execution stage.
// Throughput: one item per cycle unless the output stalls; each item gives one result.
// An accepted item passes through the input register, the two-entry queue and then the
// execution stage, whose registered memory read and result register hold its result.
// Reset is synchronous and active low; it clears control state and the registers to their
// defaults at once. The pattern memory is not cleared and holds no data until loaded.
module led_pattern_sequencer #(
    parameter int MAX_STEPS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lps_in_if.sink                        i_in,
    lps_out_if.source                     o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lps_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [lps_pkg::CfgDataW-1:0]  i_cfg_data
);
    import lps_pkg::*;

    logic    f_valid;
    logic    f_ready;
    t_cmd    f_cmd;
    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    t_cfg_wr cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    lps_front #(.MAX_STEPS(MAX_STEPS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    lps_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_cmd   (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_cmd   (q_cmd)
    );

    lps_back #(.MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .i_cfg       (cfg),
        .o_out       (o_out)
    );
endmodule

// File: rtl/lps_front.sv
// Front end: accepts input requests, decodes the action and registers a command.
module lps_front #(
    parameter int MAX_STEPS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lps_in_if.sink        i_in,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output lps_pkg::t_cmd o_cmd
);
    import lps_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic load_ok;

    assign load_ok = (32'(i_in.step_index) < MAX_STEPS);

    always_comb begin
        n_cmd.elapsed_ms  = i_in.elapsed_ms;
        n_cmd.status      = i_in.status;
        n_cmd.mode        = i_in.mode;
        n_cmd.step_index  = i_in.step_index;
        n_cmd.entry_value = i_in.entry_value;
        n_cmd.final_entry = i_in.final_entry;
        unique case (i_in.action)
            ACT_TICK:   n_cmd.op = OP_TICK;
            ACT_STATUS: n_cmd.op = OP_STATUS;
            ACT_LOAD:   n_cmd.op = load_ok ? OP_LOAD : OP_NONE;
            default:    n_cmd.op = OP_NONE;
        endcase
    end

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// File: rtl/lps_queue.sv
// Two-entry command queue between the front end and the execution stage.
module lps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  lps_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output lps_pkg::t_cmd o_rd_cmd
);
    import lps_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end
endmodule

// File: rtl/lps_back.sv
// Execution stage: sequencer state, pattern memory, registers and result register.
module lps_back #(
    parameter int MAX_STEPS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  lps_pkg::t_cmd    i_cmd,
    input  lps_pkg::t_cfg_wr i_cfg,
    lps_out_if.source        o_out
);
    import lps_pkg::*;

    localparam int AW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int PW    = $clog2(MAX_STEPS + 1);
    localparam int Depth = 4 << AW;

    logic [7:0]    r_mask;
    logic [15:0]   r_delay [4];
    logic [15:0]   r_cd;
    logic [PW-1:0] r_pos;
    logic [2:0]    r_status;
    logic [PW-1:0] r_len [4];
    logic [5:0]    r_pin;
    logic          r_out_valid;
    t_pin_src      r_src;
    logic [7:0]    r_rd;
    logic [7:0]    r_mem [Depth];

    logic [15:0]   n_cd;
    logic [PW-1:0] n_pos;
    logic [2:0]    n_status;
    t_pin_src      n_src;
    logic          rd_en;
    logic          wr_en;
    logic [PW-1:0] rd_pos;
    logic          fire;
    logic          is_play;
    logic [1:0]    m;
    logic [PW-1:0] len;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] pos_inc;
    logic          tick_step;
    logic [7:0]    masked;
    logic [5:0]    pin_cur;

    function automatic logic [5:0] to_pins(input logic [7:0] b);
        return {b[1:0], b[7:4]};
    endfunction

    assign fire        = i_cmd_valid && o_cmd_ready;
    assign o_cmd_ready = !r_out_valid || o_out.ready;

    assign is_play   = (r_status >= ST_STANDBY) && (r_status <= ST_LOCKUP);
    assign m         = 2'(r_status - ST_STANDBY);
    assign len       = r_len[m];
    assign pos_w     = (r_pos >= len) ? '0 : r_pos;
    assign pos_inc   = pos_w + PW'(1);
    assign tick_step = (r_cd <= {8'd0, i_cmd.elapsed_ms});

    always_comb begin
        n_cd     = r_cd;
        n_pos    = r_pos;
        n_status = r_status;
        n_src    = PS_HOLD;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        rd_pos   = pos_w;
        unique case (i_cmd.op)
            OP_TICK: begin
                if (!tick_step) begin
                    n_cd = r_cd - {8'd0, i_cmd.elapsed_ms};
                end else if (!is_play) begin
                    n_cd  = SLEEP_RELOAD;
                    n_src = PS_ZERO;
                end else begin
                    n_cd = r_delay[m];
                    if (len != '0) begin
                        if (m == MODE_CLASH) begin
                            if (r_pos < len) begin
                                rd_pos = r_pos;
                                n_pos  = r_pos + PW'(1);
                                rd_en  = 1'b1;
                                n_src  = PS_MEM;
                            end
                        end else begin
                            rd_pos = pos_w;
                            n_pos  = (pos_inc >= len) ? '0 : pos_inc;
                            rd_en  = 1'b1;
                            n_src  = PS_MEM;
                        end
                    end
                end
            end
            OP_STATUS: begin
                n_status = i_cmd.status;
                n_pos    = '0;
                n_cd     = '0;
            end
            OP_LOAD: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign masked = r_rd & r_mask;

    always_comb begin
        case (r_src)
            PS_ZERO: pin_cur = 6'd0;
            PS_MEM:  pin_cur = to_pins(masked);
            default: pin_cur = r_pin;
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pin_drive    = pin_cur;
    assign o_out.pins_updated = (r_src != PS_HOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MASK_RESET;
            r_delay     <= '{default: DELAY_RESET};
            r_cd        <= '0;
            r_pos       <= '0;
            r_status    <= '0;
            r_len       <= '{default: '0};
            r_pin       <= '0;
            r_out_valid <= 1'b0;
            r_src       <= PS_HOLD;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_LED_MASK:      r_mask <= i_cfg.data[7:0];
                    REG_STANDBY_DELAY: r_delay[MODE_STANDBY] <= i_cfg.data;
                    REG_ON_DELAY:      r_delay[MODE_ON] <= i_cfg.data;
                    REG_CLASH_DELAY:   r_delay[MODE_CLASH] <= i_cfg.data;
                    REG_LOCKUP_DELAY:  r_delay[MODE_LOCKUP] <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && o_out.ready) begin
                r_pin <= pin_cur;
            end
            if (fire) begin
                r_cd        <= n_cd;
                r_pos       <= n_pos;
                r_status    <= n_status;
                r_src       <= n_src;
                r_out_valid <= 1'b1;
                if (wr_en && i_cmd.final_entry) begin
                    r_len[i_cmd.mode] <= PW'(32'(i_cmd.step_index) + 1);
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            r_mem[{i_cmd.mode, AW'(i_cmd.step_index)}] <= i_cmd.entry_value;
        end
        if (fire && rd_en) begin
            r_rd <= r_mem[{m, rd_pos[AW-1:0]}];
        end
    end
endmodule

// File: verif/tb_led_pattern_sequencer.sv
// Self-checking testbench of the LED pattern sequencer, checked against a predictor.
module tb_led_pattern_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    localparam int MAX_STEPS = 64;
    localparam int REG_COUNT = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [2:0] ST_SLEEP = 3'd0;
    localparam logic [2:0] ST_ON = 3'd2;
    localparam logic [2:0] ST_CLASH = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_TOP = 3'd7;

    typedef struct packed {
        logic [5:0] pin_drive;
        logic       pins_updated;
    } t_pin_result;

    typedef struct packed {
        t_cmd        cmd;
        t_pin_result result;
    } t_queued_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    lps_in_if in_if ();
    lps_out_if out_if ();

    led_pattern_sequencer #(
        .MAX_STEPS(MAX_STEPS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor state and its copy of the registers.
    int          pred_countdown;
    int          pred_position;
    logic [2:0]  pred_status;
    logic [7:0]  pred_pattern [4*MAX_STEPS];
    bit          pred_loaded [4*MAX_STEPS];
    int          pred_length [4];
    logic [5:0]  pred_pins;
    logic [7:0]  pred_mask;
    logic [15:0] pred_delay [4];

    t_queued_cmd cmd_queue [$];
    t_pin_result expected_pins [$];
    t_queued_cmd in_flight;
    int          cmds_issued = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_gap;
    int          stall_left;
    bit          quiet_run = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL led_pattern_sequencer");
            $finish;
        end
    end

    function automatic bit play_step();
        int m;
        int pos;
        bit wrote;
        wrote = 1'b0;
        if (pred_status < ST_STANDBY || pred_status > ST_LOCKUP) begin
            pred_pins = '0;
            pred_countdown = SLEEP_RELOAD;
            wrote = 1'b1;
        end else begin
            m = pred_status - 1;
            pred_countdown = pred_delay[m];
            if (pred_length[m] != 0) begin
                pos = pred_position;
                if (m == MODE_CLASH) begin
                    if (pos < pred_length[m]) begin
                        pred_position = pos + 1;
                        wrote = 1'b1;
                    end
                end else begin
                    if (pos >= pred_length[m]) pos = 0;
                    pred_position = (pos + 1 >= pred_length[m]) ? 0 : pos + 1;
                    wrote = 1'b1;
                end
                if (wrote) begin
                    logic [7:0] b;
                    b = pred_pattern[m*MAX_STEPS + pos] & pred_mask;
                    pred_pins = {b[1:0], b[7:4]};
                end
            end
        end
        return wrote;
    endfunction

    function automatic t_pin_result advance_sequencer(input t_cmd c);
        t_pin_result r;
        int slot;
        r.pins_updated = 1'b0;
        case (c.op)
            OP_TICK: begin
                pred_countdown -= c.elapsed_ms;
                if (pred_countdown <= 0) r.pins_updated = play_step();
            end
            OP_STATUS: begin
                pred_status = c.status;
                pred_position = 0;
                pred_countdown = 0;
            end
            OP_LOAD: begin
                slot = c.mode * MAX_STEPS + c.step_index;
                pred_pattern[slot] = c.entry_value;
                pred_loaded[slot] = 1'b1;
                if (c.final_entry) pred_length[c.mode] = c.step_index + 1;
            end
            default: ;
        endcase
        r.pin_drive = pred_pins;
        return r;
    endfunction

    // Tells whether a tick would read a pattern entry that has never been loaded.
    function automatic bit step_hits_blank(input logic [7:0] elapsed, output int m,
                                           output int pos);
        bit blank;
        blank = 1'b0;
        m = 0;
        pos = pred_position;
        if (pred_countdown - int'(elapsed) <= 0 && pred_status >= ST_STANDBY
                && pred_status <= ST_LOCKUP) begin
            m = pred_status - 1;
            if (pred_length[m] != 0) begin
                if (m != MODE_CLASH && pos >= pred_length[m]) pos = 0;
                if (pos < pred_length[m]) blank = !pred_loaded[m*MAX_STEPS + pos];
            end
        end
        return blank;
    endfunction

    function automatic void enqueue(input t_cmd c);
        t_queued_cmd q;
        q.cmd = c;
        q.result = advance_sequencer(c);
        cmd_queue.push_back(q);
        cmds_issued++;
    endfunction

    function automatic void issue(input t_cmd c);
        t_cmd fill;
        int m;
        int pos;
        if (c.op == OP_TICK && step_hits_blank(c.elapsed_ms, m, pos)) begin
            fill = t_cmd'(($bits(t_cmd))'($urandom));
            fill.op = OP_LOAD;
            fill.mode = m[1:0];
            fill.step_index = pos[5:0];
            fill.final_entry = 1'b0;
            enqueue(fill);
        end
        enqueue(c);
    endfunction

    function automatic t_cmd make_cmd(input t_op op, input logic [7:0] elapsed,
                                      input logic [2:0] status, input logic [1:0] mode,
                                      input logic [5:0] idx, input logic [7:0] value,
                                      input logic fin);
        t_cmd c;
        c.op = op;
        c.elapsed_ms = elapsed;
        c.status = status;
        c.mode = mode;
        c.step_index = idx;
        c.entry_value = value;
        c.final_entry = fin;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        c = t_cmd'(($bits(t_cmd))'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            c.op = OP_TICK;
            if ($urandom_range(0, 1) == 0) c.elapsed_ms = 8'($urandom_range(0, 40));
        end else if (pick < 67) begin
            c.op = OP_STATUS;
            if ($urandom_range(0, 9) < 8)
                c.status = 3'($urandom_range(ST_STANDBY, ST_LOCKUP));
        end else if (pick < 95) begin
            c.op = OP_LOAD;
            if ($urandom_range(0, 9) < 8) c.step_index = 6'($urandom_range(0, 7));
            c.final_entry = ($urandom_range(0, 9) < 3);
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_LED_MASK:      pred_mask = data[7:0];
            REG_STANDBY_DELAY: pred_delay[MODE_STANDBY] = data;
            REG_ON_DELAY:      pred_delay[MODE_ON] = data;
            REG_CLASH_DELAY:   pred_delay[MODE_CLASH] = data;
            REG_LOCKUP_DELAY:  pred_delay[MODE_LOCKUP] = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] mask, input int lo, input int hi,
                                 input bit stray);
        logic [15:0] word;
        word = 16'($urandom);
        word[7:0] = mask;
        write_register(REG_LED_MASK, word);
        for (int r = REG_STANDBY_DELAY; r <= REG_LOCKUP_DELAY; r++) begin
            word = 16'($urandom_range(lo, hi));
            write_register(r[CfgIdxW-1:0], word);
        end
        if (stray) begin
            word = 16'($urandom);
            write_register(CfgIdxW'($urandom_range(REG_COUNT, (1 << CfgIdxW) - 1)), word);
        end
    endtask

    task automatic drain();
        while (results_checked != cmds_issued) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_result(input logic [5:0] pins, input logic updated);
        t_pin_result want;
        results_checked++;
        if (expected_pins.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected result: pin_drive %h pins_updated %b", pins, updated);
        end else begin
            want = expected_pins.pop_front();
            if (pins !== want.pin_drive || updated !== want.pins_updated) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result %0d: expected pin_drive %h pins_updated %b, got %h %b",
                             results_checked, want.pin_drive, want.pins_updated,
                             pins, updated);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_if.valid && in_if.ready) expected_pins.push_back(in_flight.result);
            if (in_if.valid && !in_if.ready) begin
                in_if.valid <= 1'b1;
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 4);
                in_if.valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                in_flight = cmd_queue.pop_front();
                in_if.valid <= 1'b1;
                in_if.action <= in_flight.cmd.op;
                in_if.elapsed_ms <= in_flight.cmd.elapsed_ms;
                in_if.status <= in_flight.cmd.status;
                in_if.mode <= in_flight.cmd.mode;
                in_if.step_index <= in_flight.cmd.step_index;
                in_if.entry_value <= in_flight.cmd.entry_value;
                in_if.final_entry <= in_flight.cmd.final_entry;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_if.valid && out_if.ready)
                compare_result(out_if.pin_drive, out_if.pins_updated);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_if.ready <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.action = '0;
        in_if.elapsed_ms = '0;
        in_if.status = '0;
        in_if.mode = '0;
        in_if.step_index = '0;
        in_if.entry_value = '0;
        in_if.final_entry = 1'b0;
        out_if.ready = 1'b0;

        pred_countdown = 0;
        pred_position = 0;
        pred_status = ST_SLEEP;
        pred_pins = '0;
        pred_mask = MASK_RESET;
        for (int m = 0; m < 4; m++) begin
            pred_length[m] = 0;
            pred_delay[m] = DELAY_RESET;
        end
        for (int s = 0; s < 4*MAX_STEPS; s++) begin
            pred_pattern[s] = '0;
            pred_loaded[s] = 1'b0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(make_cmd(OP_TICK, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_NONE, 8'hFF, ST_UNKNOWN_TOP, MODE_LOCKUP, 6'd63, 8'hFF, 1'b1));
        issue(make_cmd(OP_STATUS, 8'd0, ST_STANDBY, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd0, 8'hFF, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd1, 8'h00, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd2, 8'hA5, 1'b1));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        // Shortening the table leaves the position beyond its end.
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h5A, 1'b1));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_ON, 6'd63, 8'hFF, 1'b1));
        issue(make_cmd(OP_STATUS, 8'd0, ST_ON, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_TICK, 8'd0, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_CLASH, 6'd0, 8'h33, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_CLASH, 6'd1, 8'hCC, 1'b1));
        issue(make_cmd(OP_STATUS, 8'd0, ST_CLASH, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        repeat (3) issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_LOAD, 8'd0, ST_SLEEP, MODE_LOCKUP, 6'd0, 8'h0F, 1'b1));
        issue(make_cmd(OP_STATUS, 8'd0, ST_LOCKUP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_STATUS, 8'd0, ST_UNKNOWN_TOP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        issue(make_cmd(OP_TICK, 8'd255, ST_SLEEP, MODE_STANDBY, 6'd0, 8'h00, 1'b0));
        drain();

        load_settings(8'h00, 0, 0, 1'b0);
        repeat (100) issue(random_cmd());
        drain();

        load_settings(8'hFF, 65535, 65535, 1'b0);
        repeat (60) issue(random_cmd());
        drain();

        repeat (3) begin
            load_settings(8'($urandom), 0, 300, 1'b1);
            repeat (100) issue(random_cmd());
            drain();
        end

        load_settings(8'($urandom), 0, 300, 1'b1);
        quiet_run = 1'b1;
        repeat (100) issue(random_cmd());
        drain();

        if (mismatch_count == 0 && expected_pins.size() == 0) begin
            $display("PASS led_pattern_sequencer");
        end else begin
            $display("FAIL led_pattern_sequencer");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/led_pattern_sequencer.sv
verif/tb_led_pattern_sequencer.sv
